### rtl/rrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the reorder receive tracker.
// No dependencies; used by the channel interfaces and the top level.
package rrt_pkg;

  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 11;
  localparam int SRC_W  = 16;
  localparam int SLOT_W = 5;

  localparam int DEF_WINDOW   = 32;
  localparam int DEF_SEQ_BITS = 32;

  localparam int MIN_PKT_LEN = 6;
  localparam int HDR_LEN     = 5;

  typedef enum logic [1:0] {
    KIND_DELIVER     = 2'd0,
    KIND_ACK         = 2'd1,
    KIND_DROP_SHORT  = 2'd2,
    KIND_DROP_WINDOW = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_DECIDE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             fin;
    logic [LEN_W-1:0] len;
  } slot_entry_t;

endpackage

### rtl/rrt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for packet headers in and results out.
// Depends on rrt_pkg for field widths and the result kind type.
interface rrt_in_if;
  logic                        valid;
  logic                        ready;
  logic [rrt_pkg::SEQ_W-1:0]   seq;
  logic                        fin;
  logic [rrt_pkg::LEN_W-1:0]   pkt_len;
  logic [rrt_pkg::SRC_W-1:0]   source_id;

  modport source (output valid, output seq, output fin, output pkt_len,
                  output source_id, input ready);
  modport sink   (input valid, input seq, input fin, input pkt_len,
                  input source_id, output ready);
endinterface

interface rrt_out_if;
  logic                        valid;
  logic                        ready;
  rrt_pkg::kind_t              kind;
  logic [rrt_pkg::SEQ_W-1:0]   out_seq;
  logic [rrt_pkg::SLOT_W-1:0]  slot;
  logic [rrt_pkg::LEN_W-1:0]   payload_len;
  logic                        message_start;
  logic                        message_end;
  logic [rrt_pkg::SRC_W-1:0]   out_source;
  logic                        last;

  modport source (output valid, output kind, output out_seq, output slot,
                  output payload_len, output message_start, output message_end,
                  output out_source, output last, input ready);
  modport sink   (input valid, input kind, input out_seq, input slot,
                  input payload_len, input message_start, input message_end,
                  input out_source, input last, output ready);
endinterface

### rtl/reorder_receive_tracker.sv
`timescale 1ns / 1ps
// Receive-side reorder tracker: in-order delivery, window buffering and acks.
// Depends on rrt_pkg and the channel interfaces in rrt_if.sv.
//
// One packet header is taken per transfer on in_chan; results leave on out_chan
// through a single output register, so a new header is taken while a result
// still waits. Short, buffered, duplicate and out-of-window packets pass through
// the transfer, a remainder step for the slot index (reciprocal multiply, then
// multiply-subtract) and the decision. An in-order packet that releases k held
// packets is delivered at the decision, then one held delivery per cycle is read
// from the slot memory while out_chan does not stall, then the ack; a stall holds
// the sequencer. Held lengths and fin flags live in a WINDOW-entry memory with one
// registered read port; occupancy is flip-flops cleared by reset, no clearing pass.
module reorder_receive_tracker #(
  parameter int WINDOW   = rrt_pkg::DEF_WINDOW,
  parameter int SEQ_BITS = rrt_pkg::DEF_SEQ_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  rrt_in_if.sink      in_chan,
  rrt_out_if.source   out_chan
);

  localparam int IW = $clog2(WINDOW);
  localparam int SH = SEQ_BITS + IW;
  localparam int RW = SEQ_BITS + 1;
  localparam int PW = SEQ_BITS + RW;
  localparam int QW = PW - SH;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RW-1:0]       RECIP_C  = RW'(RECIP64);
  localparam logic [SEQ_BITS-1:0] WIN_SEQ  = SEQ_BITS'(WINDOW);
  localparam logic [IW-1:0]       WIN_LAST = IW'(WINDOW - 1);

  rrt_pkg::state_t state_r, state_nxt;

  logic [SEQ_BITS-1:0]      seq_r;
  logic                     fin_r;
  logic [rrt_pkg::LEN_W-1:0] len_r;
  logic [rrt_pkg::SRC_W-1:0] src_r;
  logic [PW-1:0]            prod_r;
  logic [IW-1:0]            slot_r;
  logic [SEQ_BITS-1:0]      dist_r;

  logic [SEQ_BITS-1:0]      exp_r;
  logic [IW-1:0]            exp_slot_r;
  logic                     in_msg_r;
  logic [IW-1:0]            cnt_r;
  logic [WINDOW-1:0]        valid_r;

  rrt_pkg::slot_entry_t     mem [WINDOW];
  rrt_pkg::slot_entry_t     rd_r;
  logic [IW-1:0]            rd_addr;

  logic                      out_valid_r;
  rrt_pkg::kind_t            o_kind_r;
  logic [rrt_pkg::SEQ_W-1:0]  o_seq_r;
  logic [rrt_pkg::SLOT_W-1:0] o_slot_r;
  logic [rrt_pkg::LEN_W-1:0]  o_len_r;
  logic                      o_start_r;
  logic                      o_end_r;
  logic [rrt_pkg::SRC_W-1:0]  o_src_r;
  logic                      o_last_r;

  logic                      emit;
  rrt_pkg::kind_t            e_kind;
  logic [SEQ_BITS-1:0]       e_seq;
  logic [IW-1:0]             e_slot;
  logic [rrt_pkg::LEN_W-1:0]  e_len;
  logic                      e_start;
  logic                      e_end;
  logic                      e_last;
  logic                      mem_we;
  logic                      advance;
  logic                      in_ready;

  logic [SEQ_BITS-1:0]       seq_in;
  logic [PW-1:0]             prod_in;
  logic [QW-1:0]             quo;
  logic [SEQ_BITS-1:0]       rem_full;
  logic [SEQ_BITS-1:0]       exp_inc;
  logic [IW-1:0]             exp_slot_inc;
  logic                      short_pkt;
  logic [rrt_pkg::LEN_W-1:0]  plen;
  logic                      in_window;
  logic                      drain_more;
  logic                      out_free;
  logic                      in_xfer;

  assign seq_in   = in_chan.seq[SEQ_BITS-1:0];
  assign prod_in  = PW'(seq_in) * PW'(RECIP_C);
  assign quo      = prod_r[PW-1:SH];
  assign rem_full = seq_r - SEQ_BITS'(quo) * WIN_SEQ;

  assign exp_inc      = exp_r + SEQ_BITS'(1);
  assign exp_slot_inc = (exp_inc == '0 || exp_slot_r == WIN_LAST) ? '0
                                                                 : exp_slot_r + IW'(1);

  assign short_pkt  = len_r < rrt_pkg::LEN_W'(rrt_pkg::MIN_PKT_LEN);
  assign plen       = len_r - rrt_pkg::LEN_W'(rrt_pkg::HDR_LEN);
  assign in_window  = dist_r < WIN_SEQ;
  assign drain_more = valid_r[exp_slot_r] && (cnt_r < WIN_LAST);
  assign out_free   = !out_valid_r || out_chan.ready;
  assign in_xfer    = in_chan.valid && in_ready;
  assign rd_addr    = advance ? exp_slot_inc : exp_slot_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrt_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = rrt_pkg::ST_MOD;
      end
      rrt_pkg::ST_MOD: begin
        state_nxt = rrt_pkg::ST_DECIDE;
      end
      rrt_pkg::ST_DECIDE: begin
        if (out_free) begin
          state_nxt = (!short_pkt && dist_r == '0) ? rrt_pkg::ST_DRAIN : rrt_pkg::ST_IDLE;
        end
      end
      rrt_pkg::ST_DRAIN: begin
        if (out_free && !drain_more) state_nxt = rrt_pkg::ST_IDLE;
      end
      default: state_nxt = rrt_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    emit     = 1'b0;
    e_kind   = rrt_pkg::KIND_ACK;
    e_seq    = seq_r;
    e_slot   = slot_r;
    e_len    = '0;
    e_start  = 1'b0;
    e_end    = 1'b0;
    e_last   = 1'b0;
    mem_we   = 1'b0;
    advance  = 1'b0;
    in_ready = 1'b0;
    unique case (state_r)
      rrt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      rrt_pkg::ST_MOD: begin
      end
      rrt_pkg::ST_DECIDE: begin
        if (out_free) begin
          emit = 1'b1;
          if (short_pkt) begin
            e_kind = rrt_pkg::KIND_DROP_SHORT;
            e_last = 1'b1;
          end else if (dist_r == '0) begin
            e_kind  = rrt_pkg::KIND_DELIVER;
            e_len   = plen;
            e_start = !in_msg_r;
            e_end   = fin_r;
            advance = 1'b1;
          end else if (in_window) begin
            e_last = 1'b1;
            mem_we = !valid_r[slot_r];
          end else if (dist_r[SEQ_BITS-1]) begin
            e_last = 1'b1;
          end else begin
            e_kind = rrt_pkg::KIND_DROP_WINDOW;
            e_last = 1'b1;
          end
        end
      end
      rrt_pkg::ST_DRAIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (drain_more) begin
            e_kind  = rrt_pkg::KIND_DELIVER;
            e_seq   = exp_r;
            e_slot  = exp_slot_r;
            e_len   = rd_r.len;
            e_start = !in_msg_r;
            e_end   = rd_r.fin;
            advance = 1'b1;
          end else begin
            e_last = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrt_pkg::ST_IDLE;
      exp_r       <= SEQ_BITS'(1);
      exp_slot_r  <= IW'(1);
      in_msg_r    <= 1'b0;
      cnt_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        valid_r[exp_slot_r] <= 1'b0;
        exp_r      <= exp_inc;
        exp_slot_r <= exp_slot_inc;
        in_msg_r   <= !e_end;
      end
      if (mem_we) valid_r[slot_r] <= 1'b1;
      if (state_r == rrt_pkg::ST_DECIDE) cnt_r <= '0;
      else if (advance) cnt_r <= cnt_r + IW'(1);
      if (emit) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      seq_r  <= seq_in;
      fin_r  <= in_chan.fin;
      len_r  <= in_chan.pkt_len;
      src_r  <= in_chan.source_id;
      prod_r <= prod_in;
    end
    if (state_r == rrt_pkg::ST_MOD) begin
      slot_r <= rem_full[IW-1:0];
      dist_r <= seq_r - exp_r;
    end
    if (emit) begin
      o_kind_r  <= e_kind;
      o_seq_r   <= rrt_pkg::SEQ_W'(e_seq);
      o_slot_r  <= rrt_pkg::SLOT_W'(e_slot);
      o_len_r   <= e_len;
      o_start_r <= e_start;
      o_end_r   <= e_end;
      o_src_r   <= src_r;
      o_last_r  <= e_last;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[slot_r] <= '{fin: fin_r, len: plen};
    rd_r <= mem[rd_addr];
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.kind          = o_kind_r;
  assign out_chan.out_seq       = o_seq_r;
  assign out_chan.slot          = o_slot_r;
  assign out_chan.payload_len   = o_len_r;
  assign out_chan.message_start = o_start_r;
  assign out_chan.message_end   = o_end_r;
  assign out_chan.out_source    = o_src_r;
  assign out_chan.last          = o_last_r;

endmodule
